// ===== sv/gnss_sentence_checksum_checker_defines.svh =====
// assertion macros used by the checker file gscc_checker.sv
`ifndef GNSS_SENTENCE_CHECKSUM_CHECKER_DEFINES_SVH
`define GNSS_SENTENCE_CHECKSUM_CHECKER_DEFINES_SVH

// checked on every edge outside reset
`define GSCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define GSCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/gscc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gscc_pkg
// Types, codes and per-byte update functions of the sentence checksum checker.
// ---------------------------------------------------------------------------
package gscc_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [15:0] MAX_FRAME_LEN = 16'hFFFF;

  localparam logic [3:0] NMEA_DIGITS = 4'd2;
  localparam logic [3:0] HASH_DIGITS = 4'd8;

  localparam logic [1:0] KIND_NMEA  = 2'd0;
  localparam logic [1:0] KIND_HASH  = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SUM    = 3'd1;
  localparam logic [2:0] ST_MISMATCH  = 3'd2;
  localparam logic [2:0] ST_MALFORMED = 3'd3;
  localparam logic [2:0] ST_UNCHECKED = 3'd4;

  typedef struct packed {
    logic        line_started;
    logic        held_return;
    logic [1:0]  kind;
    logic [31:0] crc;
    logic [31:0] crc_star;
    logic [7:0]  xsum;
    logic        star_seen;
    logic [3:0]  trl_count;
    logic [31:0] trl_value;
    logic        trl_bad;
    logic [15:0] len;
  } state_t;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [2:0]  check_status;
    logic [31:0] computed_check;
    logic [15:0] frame_length;
    logic        line_end;
  } res_t;

  localparam state_t STATE_RESET = '{
    line_started: 1'b0, held_return: 1'b0, kind: KIND_OTHER, crc: '0,
    crc_star: '0, xsum: '0, star_seen: 1'b0, trl_count: '0, trl_value: '0,
    trl_bad: 1'b0, len: '0};

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // bit 4 flags a valid hex digit
  function automatic logic [4:0] hex_value(logic [7:0] b);
    logic [4:0] h;
    h = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h = {1'b1, b[3:0]};
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      h = {1'b1, b[3:0] + 4'd9};
    end
    return h;
  endfunction

  function automatic state_t trailer_reset(state_t s);
    state_t r;
    r = s;
    r.star_seen = 1'b1;
    r.trl_count = '0;
    r.trl_value = '0;
    r.trl_bad   = 1'b0;
    return r;
  endfunction

  function automatic state_t trailer_byte(state_t s, logic [7:0] b, logic [3:0] limit);
    state_t     r;
    logic [4:0] h;
    r = s;
    h = hex_value(b);
    if (!h[4] || s.trl_count >= limit) begin
      r.trl_bad = 1'b1;
    end else begin
      r.trl_value = {s.trl_value[27:0], h[3:0]};
      r.trl_count = s.trl_count + 4'd1;
    end
    return r;
  endfunction

  function automatic state_t start_frame(state_t s, logic [7:0] b);
    state_t r;
    r = s;
    if (b == CHAR_DOLLAR) begin
      r.kind = KIND_NMEA;
    end else if (b == CHAR_HASH) begin
      r.kind = KIND_HASH;
    end else begin
      r.kind = KIND_OTHER;
    end
    r.crc          = '0;
    r.crc_star     = '0;
    r.xsum         = '0;
    r.star_seen    = 1'b0;
    r.trl_count    = '0;
    r.trl_value    = '0;
    r.trl_bad      = 1'b0;
    r.len          = 16'd1;
    r.line_started = 1'b1;
    return r;
  endfunction

  function automatic state_t feed_byte(state_t s, logic [7:0] b);
    state_t r;
    r = s;
    if (s.len < MAX_FRAME_LEN) begin
      r.len = s.len + 16'd1;
    end
    if (s.kind == KIND_NMEA) begin
      if (!s.star_seen) begin
        if (b == CHAR_STAR) begin
          r = trailer_reset(r);
        end else begin
          r.xsum = s.xsum ^ b;
        end
      end else begin
        r = trailer_byte(r, b, NMEA_DIGITS);
      end
    end else if (s.kind == KIND_HASH) begin
      if (b == CHAR_STAR) begin
        r.crc_star = s.crc;
        r = trailer_reset(r);
      end else if (s.star_seen) begin
        r = trailer_byte(r, b, HASH_DIGITS);
      end
      r.crc = crc_byte(s.crc, b);
    end
    return r;
  endfunction

  function automatic logic is_start(logic [7:0] b);
    return (b == CHAR_DOLLAR) || (b == CHAR_HASH);
  endfunction

  function automatic state_t accept_byte(state_t s, logic [7:0] b);
    state_t r;
    if (!s.line_started || is_start(b)) begin
      r = start_frame(s, b);
    end else begin
      r = feed_byte(s, b);
    end
    return r;
  endfunction

  function automatic res_t make_result(state_t s, logic ended);
    res_t r;
    r.frame_kind   = s.kind;
    r.frame_length = s.len;
    r.line_end     = ended;
    if (s.kind == KIND_NMEA) begin
      r.computed_check = {24'd0, s.xsum};
      if (!s.star_seen) begin
        r.check_status = ST_NO_SUM;
      end else if (s.trl_bad || s.trl_count != NMEA_DIGITS) begin
        r.check_status = ST_MALFORMED;
      end else begin
        r.check_status = ({24'd0, s.xsum} == s.trl_value) ? ST_OK : ST_MISMATCH;
      end
    end else if (s.kind == KIND_HASH) begin
      if (!s.star_seen) begin
        r.computed_check = s.crc;
        r.check_status   = ST_MALFORMED;
      end else begin
        r.computed_check = s.crc_star;
        if (s.trl_bad || s.trl_count != HASH_DIGITS) begin
          r.check_status = ST_MALFORMED;
        end else begin
          r.check_status = (s.crc_star == s.trl_value) ? ST_OK : ST_MISMATCH;
        end
      end
    end else begin
      r.computed_check = '0;
      r.check_status   = ST_UNCHECKED;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/gnss_sentence_checksum_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gnss_sentence_checksum_checker
// Splits a receiver byte stream into frames and checks the XOR or CRC-32
// trailer of each '$' or '#' frame; other frames are reported unchecked.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per transaction, in_tdata[7:0].
//   out_* : one transaction per closed non-empty frame. out_tuser holds the
//           frame kind, out_tdata the status, computed check and length,
//           out_tlast is high when a line feed closed the frame.
//   A frame closes on line feed or on a '$' / '#' inside a line; a carriage
//   return directly before a line feed is dropped.
// Path: an accepted byte passes through the input register to the
//   frame-state update, which also loads the output register when the
//   byte closes a frame.
// Throughput: one byte per cycle outside a stall; the CRC update over a byte
//   (two bytes when a held carriage return is replayed) is combinational.
// Reset: rst_n low clears frame state and both valid flags; no frame open.
// Stall: while out_tready is low and the output register is full, a byte
//   that closes a frame waits in the input register and in_tready drops;
//   bytes that close nothing keep flowing.
// ---------------------------------------------------------------------------
module gnss_sentence_checksum_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [2:0] check_status, [34:3] computed_check,
                                       // [50:35] frame_length, [55:51] zero
  output logic [1:0]       out_tuser,  // [1:0] frame_kind
  output logic             out_tlast   // line_end
);

  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;
  gscc_pkg::state_t      state_r;
  gscc_pkg::state_t      state_nxt;
  gscc_pkg::state_t      st_cr;
  gscc_pkg::state_t      st_src;
  gscc_pkg::res_t        res_nxt;
  gscc_pkg::res_t        res_r;
  logic                  out_valid_r;
  logic                  emit;
  logic                  go;

  always_comb begin
    // replay a held carriage return before the current byte
    st_cr = state_r.held_return ? gscc_pkg::accept_byte(state_r, gscc_pkg::CHAR_CR)
                                : state_r;
    st_cr.held_return = 1'b0;
    if (s1_byte_r == gscc_pkg::CHAR_LF) begin
      st_src    = state_r;
      emit      = state_r.line_started;
      state_nxt = state_r;
      state_nxt.held_return  = 1'b0;
      state_nxt.line_started = 1'b0;
      state_nxt.kind         = gscc_pkg::KIND_OTHER;
      state_nxt.len          = '0;
    end else if (s1_byte_r == gscc_pkg::CHAR_CR) begin
      st_src    = st_cr;
      emit      = 1'b0;
      state_nxt = st_cr;
      state_nxt.held_return = 1'b1;
    end else begin
      st_src    = st_cr;
      emit      = st_cr.line_started && gscc_pkg::is_start(s1_byte_r);
      state_nxt = gscc_pkg::accept_byte(st_cr, s1_byte_r);
    end
    res_nxt = gscc_pkg::make_result(st_src, s1_byte_r == gscc_pkg::CHAR_LF);
  end

  assign go        = s1_valid_r && (!emit || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gscc_pkg::STATE_RESET;
    end else if (go) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.frame_length, res_r.computed_check, res_r.check_status};
  assign out_tuser  = res_r.frame_kind;
  assign out_tlast  = res_r.line_end;

endmodule
`default_nettype wire

// ===== sv/gscc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gscc_checker
// Port-level checks of the sentence checksum checker, bound to the top level.
// ---------------------------------------------------------------------------
`include "gnss_sentence_checksum_checker_defines.svh"

module gscc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  logic unused_in;
  assign unused_in = in_tvalid ^ in_tready ^ (^in_tdata) ^ out_tlast;

  `GSCC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `GSCC_ASSERT(a_other_unchecked, out_tvalid && out_tuser == gscc_pkg::KIND_OTHER |-> out_tdata[2:0] == gscc_pkg::ST_UNCHECKED && out_tdata[34:3] == 32'd0, "other frame not reported as unchecked")
  `GSCC_ASSERT(a_nmea_narrow, out_tvalid && out_tuser == gscc_pkg::KIND_NMEA |-> out_tdata[34:11] == 24'd0 && out_tdata[2:0] != gscc_pkg::ST_UNCHECKED, "dollar frame check wider than a byte")
  `GSCC_ASSERT(a_len_nonzero, out_tvalid |-> out_tdata[50:35] != 16'd0 && out_tuser != 2'd3, "empty or unknown frame reported")
  `GSCC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind gnss_sentence_checksum_checker gscc_checker u_gscc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
